>>> src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

>>> src/see_pkg.sv
// Types and constants for the Sobel edge enhancer.
`default_nettype none
package see_pkg;
    localparam int unsigned PixW = 8;
    localparam int unsigned CfgW = 12;
    localparam int unsigned GradW = 12;
    localparam int unsigned SqW = 21;
    localparam int unsigned MagW = 11;
    localparam int unsigned RemW = SqW + 2;
    localparam logic [7:0] PixMax = 8'd255;
    localparam logic [0:0] RegWidth = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;
    localparam logic [CfgW-1:0] WidthReset = 12'd640;
    localparam logic [CfgW-1:0] HeightReset = 12'd480;

    typedef logic [PixW-1:0] t_pix;

    // Window taps and flags carried from the window stage to the math.
    typedef struct packed {
        t_pix [8:0] win;
        logic       last;
    } t_win;

    // Partial remainder and result of the digit-by-digit square root.
    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [MagW-1:0] res;
    } t_root;

    // One square root step: bring down two bits and try the next result bit.
    function automatic t_root root_step(input t_root s, input logic [1:0] bits);
        t_root o;
        logic [RemW-1:0] trial;
        o.rem = {s.rem[RemW-3:0], bits};
        trial = {{(RemW - MagW - 2){1'b0}}, s.res, 2'b01};
        if (o.rem >= trial) begin
            o.rem = o.rem - trial;
            o.res = {s.res[MagW-2:0], 1'b1};
        end else begin
            o.res = {s.res[MagW-2:0], 1'b0};
        end
        return o;
    endfunction
endpackage
`default_nettype wire

>>> src/see_math.sv
// Sobel gradient, magnitude and enhancement pipeline.
`default_nettype none
module see_math
    `include "assert_macros.svh"
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire see_pkg::t_win i_win,
    input  wire logic          i_hold,
    output logic               o_valid,
    output see_pkg::t_pix      o_mag,
    output see_pkg::t_pix      o_enh,
    output logic               o_last
);
    import see_pkg::*;

    // Lowest root bit formed in the first and in the second root stage.
    localparam int RootLoA = 7;
    localparam int RootLoB = 3;

    logic signed [GradW-1:0] r_gx, r_gy;
    logic signed [GradW-1:0] n_gx, n_gy;
    logic [SqW-1:0] r_sq, n_sq;
    logic [SqW-1:0] r_sq1, r_sq2;
    logic [2*MagW-1:0] sq_x, sq_y;
    logic [2*MagW-1:0] sq_a, sq_b, sq_c;
    t_root n_rt1, n_rt2, n_rt3;
    t_root r_rt1, r_rt2;
    t_pix r_c1, r_c2, r_c3, r_c4;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_l1, r_l2, r_l3, r_l4;
    logic [GradW-1:0] ax, ay;
    logic [MagW-1:0] root;
    t_pix mag;
    logic [PixW:0] sum;

    // Stage one: the signed sums.
    always_comb begin
        n_gx = GradW'(i_win.win[2]) + GradW'({i_win.win[5], 1'b0}) + GradW'(i_win.win[8])
             - GradW'(i_win.win[0]) - GradW'({i_win.win[3], 1'b0}) - GradW'(i_win.win[6]);
        n_gy = GradW'(i_win.win[6]) + GradW'({i_win.win[7], 1'b0}) + GradW'(i_win.win[8])
             - GradW'(i_win.win[0]) - GradW'({i_win.win[1], 1'b0}) - GradW'(i_win.win[2]);
    end

    // Stage two: the sum of squares.
    assign ax = r_gx[GradW-1] ? GradW'(-r_gx) : GradW'(r_gx);
    assign ay = r_gy[GradW-1] ? GradW'(-r_gy) : GradW'(r_gy);
    assign sq_x = ax[10:0] * ax[10:0];
    assign sq_y = ay[10:0] * ay[10:0];
    assign n_sq = SqW'(sq_x + sq_y);

    // Stages three to five: the root, a few result bits per stage.
    assign sq_a = {{(2 * MagW - SqW){1'b0}}, r_sq};
    assign sq_b = {{(2 * MagW - SqW){1'b0}}, r_sq1};
    assign sq_c = {{(2 * MagW - SqW){1'b0}}, r_sq2};

    always_comb begin
        n_rt1 = '0;
        for (int i = MagW - 1; i >= RootLoA; i--) begin
            n_rt1 = root_step(n_rt1, sq_a[2*i +: 2]);
        end
    end

    always_comb begin
        n_rt2 = r_rt1;
        for (int i = RootLoA - 1; i >= RootLoB; i--) begin
            n_rt2 = root_step(n_rt2, sq_b[2*i +: 2]);
        end
    end

    always_comb begin
        n_rt3 = r_rt2;
        for (int i = RootLoB - 1; i >= 0; i--) begin
            n_rt3 = root_step(n_rt3, sq_c[2*i +: 2]);
        end
    end

    // Last stage: clamp and enhancement.
    assign root = n_rt3.res;
    assign mag = (root > MagW'(PixMax)) ? PixMax : root[PixW-1:0];
    assign sum = {1'b0, r_c4} + {1'b0, mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            o_valid <= 1'b0;
        end else if (!i_hold) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            o_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_hold) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
            r_c1 <= i_win.win[4];
            r_l1 <= i_win.last;
            r_sq <= n_sq;
            r_c2 <= r_c1;
            r_l2 <= r_l1;
            r_rt1 <= n_rt1;
            r_sq1 <= r_sq;
            r_c3 <= r_c2;
            r_l3 <= r_l2;
            r_rt2 <= n_rt2;
            r_sq2 <= r_sq1;
            r_c4 <= r_c3;
            r_l4 <= r_l3;
            o_mag <= mag;
            o_enh <= sum[PixW] ? PixMax : sum[PixW-1:0];
            o_last <= r_l4;
        end
    end

    `ASSERT_CLK(a_enh_ge_mag, i_clk, i_rst_n, o_valid |-> (o_enh >= o_mag), "enhanced below magnitude")
    `ASSERT_CLK(a_hold_keeps, i_clk, i_rst_n, $past(i_hold) && $past(o_valid) |-> o_valid && $stable(o_mag), "held result changed")
    `ASSERT_CLK(a_sq_bound, i_clk, i_rst_n, r_sq <= SqW'(2 * 1020 * 1020), "square sum out of range")
endmodule
`default_nettype wire

>>> src/sobel_edge_enhance.sv
// Sobel edge enhancer: one pixel per cycle in, one result per interior pixel out.
// Throughput: one pixel per cycle while no result waits at the output; the line store
// takes one read and one write a cycle.
// A result waiting at the output freezes the whole pipeline and stalls the input.
// Reset is synchronous active low; counters clear, line stores are not cleared.
`default_nettype none
module sobel_edge_enhance #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic                     i_cfg_index,
    input  wire logic [see_pkg::CfgW-1:0] i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire see_pkg::t_pix            i_pixel,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output see_pkg::t_pix                 o_edge_magnitude,
    output see_pkg::t_pix                 o_enhanced_pixel,
    output logic                          o_frame_last
);
    import see_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned ColW = $clog2(MAX_WIDTH + 1);

    logic [CfgW-1:0] r_width, r_height;
    logic [ColW-1:0] r_col, n_col, eff_w;
    logic [CfgW-1:0] r_row, n_row, eff_h;
    logic [2*PixW-1:0] mem [MAX_WIDTH];
    logic [2*PixW-1:0] r_rd;
    logic [ColW-1:0] r_col_d;
    t_pix r_px;
    logic r_s1, r_last1, r_int1;
    t_pix [8:0] r_win;
    logic r_wv, r_wlast;
    t_win win_bus;
    logic hold, acc;

    // Clamp the configured size.
    always_comb begin
        if (r_width < 12'd3) eff_w = ColW'(3);
        else if (ColW'(r_width) > ColW'(MAX_WIDTH) || (CfgW > ColW && r_width > CfgW'(MAX_WIDTH)))
            eff_w = ColW'(MAX_WIDTH);
        else eff_w = ColW'(r_width);
        eff_h = (r_height < 12'd3) ? 12'd3 : r_height;
    end

    assign hold = o_valid && !i_ready;
    assign o_ready = !hold;
    assign o_cfg_ready = 1'b1;
    assign acc = i_valid && o_ready;

    // Raster counters.
    always_comb begin
        n_col = r_col + 1'b1;
        n_row = r_row;
        if (n_col >= eff_w) begin
            n_col = '0;
            n_row = (r_row + 1'b1 >= eff_h) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WidthReset;
            r_height <= HeightReset;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == RegWidth) r_width <= i_cfg_data;
            else r_height <= i_cfg_data;
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line store: one entry holds the pixel one and two lines up.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= mem[r_col[AW-1:0]];
        end
        if (r_s1 && !hold) begin
            mem[r_col_d[AW-1:0]] <= {r_rd[PixW-1:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
            r_wv <= 1'b0;
        end else if (!hold) begin
            r_s1 <= acc;
            r_wv <= r_s1 && r_int1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold) begin
            if (acc) begin
                r_px <= i_pixel;
                r_col_d <= r_col;
                r_int1 <= (r_row >= 12'd2) && (r_col >= ColW'(2));
                r_last1 <= (r_row == eff_h - 1'b1) && (r_col == eff_w - 1'b1);
            end
            r_wlast <= r_last1;
        end
    end

    // Window shift: same-entry hazard never arises since a column repeats only
    // after at least three pixels, and each write lands no later than the next pixel's read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1 && !hold) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[2] <= r_rd[2*PixW-1:PixW];
            r_win[5] <= r_rd[PixW-1:0];
            r_win[8] <= r_px;
        end
    end

    assign win_bus.win = r_win;
    assign win_bus.last = r_wlast;

    see_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_wv),
        .i_win   (win_bus),
        .i_hold  (hold),
        .o_valid (o_valid),
        .o_mag   (o_edge_magnitude),
        .o_enh   (o_enhanced_pixel),
        .o_last  (o_frame_last)
    );

    `ASSERT_CLK(a_col_range, i_clk, i_rst_n, r_col < eff_w, "column past width")
    `ASSERT_CLK(a_row_range, i_clk, i_rst_n, r_row < eff_h, "row past height")
    `ASSERT_CLK(a_stall, i_clk, i_rst_n, hold |-> !o_ready, "accepted while stalled")
endmodule
`default_nettype wire

>>> sim/sobel_edge_enhance_tb.sv
// Testbench for the Sobel edge enhancer: streams frames and checks each result against a predictor.
module sobel_edge_enhance_tb;
    import see_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic            i_cfg_index;
    logic [CfgW-1:0] i_cfg_data;
    logic            i_valid;
    logic            o_ready;
    t_pix            i_pixel;
    logic            o_valid;
    logic            i_ready;
    t_pix            o_edge_magnitude;
    t_pix            o_enhanced_pixel;
    logic            o_frame_last;

    // One expected output beat.
    typedef struct packed {
        t_pix mag;
        t_pix enh;
        logic last;
    } t_sobel_out;

    // Pixel patterns for a whole frame.
    typedef enum int {
        PatRandom  = 0,
        PatZero    = 1,
        PatMax     = 2,
        PatChecker = 3
    } t_pattern;

    t_sobel_out sobel_expected_q[$];

    // Predictor state.
    int unsigned pred_width;
    int unsigned pred_height;
    t_pix        prev_line[2048];
    t_pix        prev_prev_line[2048];
    t_pix        window[9];
    int unsigned pred_col;
    int unsigned pred_row;

    int error_count;
    int result_count;
    int pixel_count;
    int send_idle_pct;
    int recv_stall_pct;

    sobel_edge_enhance dut (.*);

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor square root by bitwise trial.
    function automatic int unsigned floor_sqrt(input int unsigned v);
        int unsigned res;
        int unsigned bitv;
        res = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Advance the predictor by one pixel and queue any result.
    task automatic predict_pixel(input t_pix px);
        int unsigned w;
        int unsigned h;
        int signed gx;
        int signed gy;
        int unsigned mag;
        int unsigned enh;
        t_pix up1;
        t_pix up2;
        t_sobel_out r;
        w = (pred_width < 3) ? 3 : ((pred_width > 2048) ? 2048 : pred_width);
        h = (pred_height < 3) ? 3 : pred_height;
        up2 = prev_prev_line[pred_col];
        up1 = prev_line[pred_col];
        prev_prev_line[pred_col] = up1;
        prev_line[pred_col] = px;
        for (int r3 = 0; r3 < 3; r3++) begin
            window[r3*3] = window[r3*3+1];
            window[r3*3+1] = window[r3*3+2];
        end
        window[2] = up2;
        window[5] = up1;
        window[8] = px;
        if (pred_row >= 2 && pred_col >= 2) begin
            gx = (int'(window[2]) + 2*int'(window[5]) + int'(window[8]))
               - (int'(window[0]) + 2*int'(window[3]) + int'(window[6]));
            gy = (int'(window[6]) + 2*int'(window[7]) + int'(window[8]))
               - (int'(window[0]) + 2*int'(window[1]) + int'(window[2]));
            mag = floor_sqrt(gx*gx + gy*gy);
            if (mag > 255) mag = 255;
            enh = window[4] + mag;
            if (enh > 255) enh = 255;
            r.mag = mag[7:0];
            r.enh = enh[7:0];
            r.last = (pred_row == h - 1) && (pred_col == w - 1);
            sobel_expected_q.push_back(r);
        end
        pred_col++;
        if (pred_col >= w) begin
            pred_col = 0;
            pred_row++;
            if (pred_row >= h) pred_row = 0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Send one pixel beat, with optional idle cycles before it. Valid stays
    // high after the beat so that back-to-back beats need no gap.
    task automatic send_pixel(input t_pix px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_pixel(px);
        pixel_count++;
        @(negedge i_clk);
    endtask

    // Stop sending, wait until every expected result has arrived, then let the pipe drain.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sobel_expected_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_register(input logic idx, input logic [CfgW-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == RegWidth) pred_width = data;
        else pred_height = data;
        pred_col = 0;
        pred_row = 0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        write_register(RegWidth, w[CfgW-1:0]);
        write_register(RegHeight, h[CfgW-1:0]);
    endtask

    // Send a whole frame in the given pattern.
    task automatic send_frame(input int unsigned w, input int unsigned h, input t_pattern mode);
        t_pix px;
        for (int unsigned y = 0; y < h; y++) begin
            for (int unsigned x = 0; x < w; x++) begin
                case (mode)
                    PatZero: px = 8'd0;
                    PatMax: px = PixMax;
                    PatChecker: px = ((x + y) % 2) ? PixMax : 8'd0;
                    default: px = $urandom_range(255);
                endcase
                send_pixel(px);
            end
        end
    endtask

    // Checker: compare each output beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (sobel_expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                t_sobel_out e;
                e = sobel_expected_q.pop_front();
                result_count++;
                if (o_edge_magnitude !== e.mag)
                    report_mismatch($sformatf("magnitude %0d, expected %0d",
                                              o_edge_magnitude, e.mag));
                if (o_enhanced_pixel !== e.enh)
                    report_mismatch($sformatf("enhanced %0d, expected %0d",
                                              o_enhanced_pixel, e.enh));
                if (o_frame_last !== e.last)
                    report_mismatch($sformatf("frame_last %0b, expected %0b",
                                              o_frame_last, e.last));
            end
        end
    end

    // Receiver readiness, changed at the falling edge.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Directed: extreme images and the smallest legal frame, plus saturated sizes.
    task automatic test_directed();
        set_frame(3, 3);
        send_frame(3, 3, PatZero);
        send_frame(3, 3, PatMax);
        send_frame(3, 3, PatChecker);
        // Widths and heights below range act as the minimum.
        set_frame(0, 1);
        send_frame(3, 3, PatChecker);
    endtask

    // Reset sizes: part of the first line, which must give no result.
    task automatic test_reset_size_lines();
        for (int i = 0; i < 150; i++) send_pixel($urandom_range(255));
    endtask

    // Widest setting and width clamping above the maximum, over part of a line.
    task automatic test_wide();
        set_frame(4095, 3);
        for (int i = 0; i < 100; i++) send_pixel($urandom_range(255));
        set_frame(2048, 4095);
        for (int i = 0; i < 100; i++) send_pixel($urandom_range(255));
    endtask

    // Random small frames under each idling phase.
    task automatic test_random_frames(input int idle, input int stall, input int target);
        int unsigned w;
        int unsigned h;
        int start;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        start = pixel_count;
        while (pixel_count - start < target) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            set_frame(w, h);
            send_frame(w, h, ($urandom_range(9) == 0) ?
                       t_pattern'($urandom_range(1, 3)) : PatRandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = RegWidth;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel = '0;
        i_ready = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        result_count = 0;
        pixel_count = 0;
        pred_width = WidthReset;
        pred_height = HeightReset;
        pred_col = 0;
        pred_row = 0;
        for (int i = 0; i < 9; i++) window[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_size_lines();
        test_directed();
        test_wide();
        test_random_frames(0, 0, 180);
        test_random_frames(80, 0, 180);
        test_random_frames(0, 80, 180);
        test_random_frames(11, 11, 180);
        wait_drained();

        $display("Sent %0d pixels in small frames up to 12x8 and partial wide lines, checked %0d results.",
                 pixel_count, result_count);
        $display("Idling phases: none, sender 80%%, receiver 80%%, both 11%%.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
